// ----- rtl/core/kbq_pkg.sv -----
// Shared types and constants for the knob and button qualifier.
package kbq_pkg;

  // Field widths fixed by the register map and result format
  localparam int PATTERN_W  = 8;
  localparam int COUNT_W    = 24;
  localparam int PAIR_W     = 2;
  localparam int PAIR_HIST_W = 4;
  localparam int STORE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Encoder transition qualification and step signatures
  localparam logic [15:0]          VALID_PAIR_MASK = 16'h6996;
  localparam logic [STORE_W-1:0]   STORE_CLOCKWISE = 8'hE8;
  localparam logic [STORE_W-1:0]   STORE_ANTICLOCKWISE = 8'h2B;
  localparam logic [COUNT_W-1:0]   COUNT_MAX = 24'hFF_FFFF;

  // Register reset values
  localparam logic [PATTERN_W-1:0] PRESS_PATTERN_RST   = 8'd127;
  localparam logic [PATTERN_W-1:0] RELEASE_PATTERN_RST = 8'd128;
  localparam logic [COUNT_W-1:0]   IDLE_LIMIT_RST      = 24'd100000;

  // Rotation codes
  localparam logic signed [1:0] DIR_NONE = 2'sd0;
  localparam logic signed [1:0] DIR_CW   = 2'sd1;
  localparam logic signed [1:0] DIR_ACW  = -2'sd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_PATTERN   = 2'd0,
    CFG_RELEASE_PATTERN = 2'd1,
    CFG_IDLE_LIMIT      = 2'd2
  } cfg_idx_t;

  // Match flags of one button
  typedef struct packed {
    logic pressed;
    logic released;
  } btn_flags_t;

endpackage

// ----- rtl/core/kbq_if.sv -----
// Channel interfaces: sample input, result output and register write port.
interface kbq_in_if;
  logic valid;
  logic ready;
  logic wake_button_level;
  logic click_button_pin;
  logic quad_a;
  logic quad_b;

  modport source (output valid, wake_button_level, click_button_pin, quad_a, quad_b,
                  input ready);
  modport sink   (input valid, wake_button_level, click_button_pin, quad_a, quad_b,
                  output ready);
endinterface

interface kbq_out_if;
  logic              valid;
  logic              ready;
  logic              event_flag;
  logic              wake_pressed;
  logic              wake_released;
  logic              click_pressed;
  logic              click_released;
  logic signed [1:0] turn_direction;
  logic              standby_request;

  modport source (output valid, event_flag, wake_pressed, wake_released, click_pressed,
                  click_released, turn_direction, standby_request, input ready);
  modport sink   (input valid, event_flag, wake_pressed, wake_released, click_pressed,
                  click_released, turn_direction, standby_request, output ready);
endinterface

interface kbq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kbq_pkg::CFG_IDX_W-1:0]   index;
  logic [kbq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/kbq_debounce.sv -----
// Button history shift register with press and release pattern match.
module kbq_debounce #(
  parameter int HISTORY_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            level,
  input  logic [kbq_pkg::PATTERN_W-1:0]   press_pattern,
  input  logic [kbq_pkg::PATTERN_W-1:0]   release_pattern,
  output kbq_pkg::btn_flags_t             flags
);

  localparam int CMP_W = (HISTORY_BITS > kbq_pkg::PATTERN_W) ? HISTORY_BITS
                                                              : kbq_pkg::PATTERN_W;

  logic [HISTORY_BITS-1:0] history;
  logic [HISTORY_BITS-1:0] history_next;
  logic [CMP_W-1:0]        hist_ext;
  logic [CMP_W-1:0]        press_ext;
  logic [CMP_W-1:0]        release_ext;

  // Shift the new level in at the bottom
  assign history_next = {history[HISTORY_BITS-2:0], level};

  // Compare zero-extended so wide patterns never match a short history
  assign hist_ext    = CMP_W'(history_next);
  assign press_ext   = CMP_W'(press_pattern);
  assign release_ext = CMP_W'(release_pattern);

  assign flags.pressed  = (hist_ext == press_ext);
  assign flags.released = (hist_ext == release_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (advance) begin
      history <= history_next;
    end
  end

endmodule

// ----- rtl/core/kbq_quad_decoder.sv -----
// Quadrature decoder: qualifies pair transitions and detects full steps.
module kbq_quad_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              quad_a,
  input  logic              quad_b,
  output logic signed [1:0] turn_direction
);

  logic [kbq_pkg::PAIR_HIST_W-1:0] pair_history;
  logic [kbq_pkg::PAIR_HIST_W-1:0] pair_history_next;
  logic [kbq_pkg::STORE_W-1:0]     valid_pair_store;
  logic [kbq_pkg::STORE_W-1:0]     valid_pair_store_next;
  logic                            pair_ok;

  // Previous and current pair form the transition code
  assign pair_history_next = {pair_history[kbq_pkg::PAIR_W-1:0], quad_a, quad_b};
  assign pair_ok           = kbq_pkg::VALID_PAIR_MASK[pair_history_next];

  // Only legal transitions enter the store
  assign valid_pair_store_next = pair_ok
      ? {valid_pair_store[kbq_pkg::PAIR_HIST_W-1:0], pair_history_next}
      : valid_pair_store;

  // Full detent when the last two transitions match a signature
  always_comb begin
    turn_direction = kbq_pkg::DIR_NONE;
    if (pair_ok) begin
      if (valid_pair_store_next == kbq_pkg::STORE_CLOCKWISE) begin
        turn_direction = kbq_pkg::DIR_CW;
      end else if (valid_pair_store_next == kbq_pkg::STORE_ANTICLOCKWISE) begin
        turn_direction = kbq_pkg::DIR_ACW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_history     <= '0;
      valid_pair_store <= '0;
    end else if (advance) begin
      pair_history     <= pair_history_next;
      valid_pair_store <= valid_pair_store_next;
    end
  end

endmodule

// ----- rtl/core/kbq_idle_timer.sv -----
// Saturating idle tick counter with standby threshold compare.
module kbq_idle_timer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          event_seen,
  input  logic [kbq_pkg::COUNT_W-1:0]   idle_limit,
  output logic                          standby_request
);

  logic [kbq_pkg::COUNT_W-1:0] idle_count;
  logic [kbq_pkg::COUNT_W-1:0] idle_count_next;

  // Clear on any event, else count up and hold at full scale
  always_comb begin
    if (event_seen) begin
      idle_count_next = '0;
    end else if (idle_count == kbq_pkg::COUNT_MAX) begin
      idle_count_next = idle_count;
    end else begin
      idle_count_next = idle_count + 1'b1;
    end
  end

  assign standby_request = (idle_count_next > idle_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= '0;
    end else if (advance) begin
      idle_count <= idle_count_next;
    end
  end

endmodule

// ----- rtl/core/knob_and_button_qualifier_top.sv -----
// Each accepted sample item is registered into the result register, valid in the cycle after acceptance.
// Throughput: one item per cycle; the result register refills whenever it is
// empty or being taken, so the sample side stalls only while output is held.
// Reset (rst, synchronous): histories, encoder store and idle count clear,
// registers return to press 127, release 128, idle limit 100000.
module knob_and_button_qualifier_top #(
  parameter int HISTORY_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  kbq_in_if.sink  in_ch,
  kbq_out_if.source out_ch,
  kbq_cfg_if.sink cfg_ch
);

  logic [kbq_pkg::PATTERN_W-1:0] press_pattern;
  logic [kbq_pkg::PATTERN_W-1:0] release_pattern;
  logic [kbq_pkg::COUNT_W-1:0]   idle_limit;

  logic                 advance;
  kbq_pkg::btn_flags_t  wake_flags;
  kbq_pkg::btn_flags_t  click_flags;
  logic signed [1:0]    turn_dir;
  logic                 event_seen;
  logic                 standby;

  // Register write port, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_pattern   <= kbq_pkg::PRESS_PATTERN_RST;
      release_pattern <= kbq_pkg::RELEASE_PATTERN_RST;
      idle_limit      <= kbq_pkg::IDLE_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (kbq_pkg::cfg_idx_t'(cfg_ch.index))
        kbq_pkg::CFG_PRESS_PATTERN:
          press_pattern <= cfg_ch.data[kbq_pkg::PATTERN_W-1:0];
        kbq_pkg::CFG_RELEASE_PATTERN:
          release_pattern <= cfg_ch.data[kbq_pkg::PATTERN_W-1:0];
        kbq_pkg::CFG_IDLE_LIMIT:
          idle_limit <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Take a sample when the result register is free or draining
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign advance     = in_ch.valid && in_ch.ready;

  kbq_debounce #(.HISTORY_BITS(HISTORY_BITS)) u_wake (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .level           (in_ch.wake_button_level),
    .press_pattern   (press_pattern),
    .release_pattern (release_pattern),
    .flags           (wake_flags)
  );

  // Pull-up pin: low means pressed
  kbq_debounce #(.HISTORY_BITS(HISTORY_BITS)) u_click (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .level           (!in_ch.click_button_pin),
    .press_pattern   (press_pattern),
    .release_pattern (release_pattern),
    .flags           (click_flags)
  );

  kbq_quad_decoder u_quad (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .quad_a         (in_ch.quad_a),
    .quad_b         (in_ch.quad_b),
    .turn_direction (turn_dir)
  );

  assign event_seen = wake_flags.pressed || wake_flags.released ||
                      click_flags.pressed || click_flags.released ||
                      (turn_dir != kbq_pkg::DIR_NONE);

  kbq_idle_timer u_idle (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .event_seen      (event_seen),
    .idle_limit      (idle_limit),
    .standby_request (standby)
  );

  // Result register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.event_flag      <= event_seen;
      out_ch.wake_pressed    <= wake_flags.pressed;
      out_ch.wake_released   <= wake_flags.released;
      out_ch.click_pressed   <= click_flags.pressed;
      out_ch.click_released  <= click_flags.released;
      out_ch.turn_direction  <= turn_dir;
      out_ch.standby_request <= standby;
    end
  end

endmodule

// ----- rtl/core/kbq_checker.sv -----
// Port-level checks for the knob and button qualifier, bound to the top level.
module kbq_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              event_flag,
  input logic              wake_pressed,
  input logic              wake_released,
  input logic              click_pressed,
  input logic              click_released,
  input logic signed [1:0] turn_direction,
  input logic              standby_request
);

  // Every accepted sample yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // Event flag is exactly the OR of the individual indications
  a_event_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_flag == (wake_pressed || wake_released || click_pressed ||
                                 click_released || turn_direction != 2'sd0))
    else $error("event flag disagrees with indications");

  // An event clears the idle count, so standby cannot be requested with it
  a_event_no_standby: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_flag |-> !standby_request)
    else $error("standby raised on an event item");

  // Rotation code is never the unused value
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> turn_direction != 2'b10)
    else $error("illegal rotation code");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_flag) &&
      $stable(turn_direction) && $stable(standby_request))
    else $error("stalled result changed");

endmodule

bind knob_and_button_qualifier_top kbq_checker u_kbq_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .event_flag      (out_ch.event_flag),
  .wake_pressed    (out_ch.wake_pressed),
  .wake_released   (out_ch.wake_released),
  .click_pressed   (out_ch.click_pressed),
  .click_released  (out_ch.click_released),
  .turn_direction  (out_ch.turn_direction),
  .standby_request (out_ch.standby_request)
);
